// ===== rtl/first_fit_coalescing_allocator_assert.svh =====
// Assertion macros used by the allocator checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffca: next-cycle check failed");

`endif

// ===== rtl/ffca_pkg.sv =====
// ---------------------------------------------------------------------------
// ffca_pkg
// Types, codes and constants shared by the first-fit allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

    // Stored address width: region ends never pass 2^33 plus a header.
    localparam int SW = 34;

    localparam int HDR_BYTES = 32;
    localparam int GRAIN     = 16;
    localparam int MIN_SPLIT = 16;

    localparam int DEF_MAX_FREE_EXTENTS = 64;
    localparam int DEF_MAX_USED_BLOCKS  = 64;
    localparam int DEF_ADDR_BITS        = 32;

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_REGION = 2'd2,
        KIND_SHRINK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTALLOC = 3'd3,
        ST_FULL     = 3'd4,
        ST_GROW     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG1,
        S_REG2,
        S_FSCAN,
        S_VSCAN,
        S_ACOM,
        S_USCAN,
        S_SHRK,
        S_MRG1,
        S_MRG2,
        S_SHIFT,
        S_INSFIN,
        S_DONE
    } seq_state_t;

    // One table entry: header or payload address, and payload bytes.
    typedef struct packed {
        logic [SW-1:0] start;
        logic [31:0]   bytes;
    } ext_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] request_size;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] payload_address;
        logic [31:0] granted_size;
    } res_t;

    // Round a byte count up to the allocation grain.
    function automatic logic [32:0] round_grain(input logic [31:0] v);
        return ({1'b0, v} + 33'(GRAIN - 1)) & ~33'(GRAIN - 1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ffca_req_if.sv =====
// ---------------------------------------------------------------------------
// ffca_req_if
// Request channel: one word per allocator operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffca_req_if import ffca_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] request_size;

    modport source (output valid, output kind, output address, output request_size,
                    input ready);
    modport sink (input valid, input kind, input address, input request_size,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ffca_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ffca_rsp_if
// Response channel: one word per completed operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffca_rsp_if import ffca_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] payload_address;
    logic [31:0] granted_size;

    modport source (output valid, output status, output payload_address,
                    output granted_size, input ready);
    modport sink (input valid, input status, input payload_address,
                  input granted_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffca_ram.sv =====
// ---------------------------------------------------------------------------
// ffca_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ffca_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 66
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wa,
    input  wire logic [WIDTH-1:0]         wd,
    input  wire logic [$clog2(DEPTH)-1:0] ra,
    output logic      [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Registered read port; returns old data on a same-address write.
    always_ff @(posedge clk)
    begin
        rd <= mem[ra];
    end

endmodule

`default_nettype wire

// ===== rtl/ffca_seq.sv =====
// ---------------------------------------------------------------------------
// ffca_seq
// Operation sequencer: scans, merges and shifts the free and used tables.
// ---------------------------------------------------------------------------
`default_nettype none

module ffca_seq import ffca_pkg::*; #(
    parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
    parameter int MAX_USED_BLOCKS  = DEF_MAX_USED_BLOCKS,
    parameter int ADDR_BITS        = DEF_ADDR_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire req_t                                req_in,
    output logic                                     idle,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output res_t                                     res,
    output logic [$clog2(MAX_FREE_EXTENTS)-1:0]      f_ra,
    input  wire ext_t                                f_rd,
    output logic                                     f_we,
    output logic [$clog2(MAX_FREE_EXTENTS)-1:0]      f_wa,
    output ext_t                                     f_wd,
    output logic [$clog2(MAX_USED_BLOCKS)-1:0]       u_ra,
    input  wire ext_t                                u_rd,
    output logic                                     u_we,
    output logic [$clog2(MAX_USED_BLOCKS)-1:0]       u_wa,
    output ext_t                                     u_wd
);

    localparam int FW  = $clog2(MAX_FREE_EXTENTS);
    localparam int UW  = $clog2(MAX_USED_BLOCKS);
    localparam int IW  = ((FW > UW) ? FW : UW) + 1;
    localparam int AMW = (ADDR_BITS < 33) ? ADDR_BITS : 33;
    localparam logic [SW-1:0] ADDR_MASK = (SW'(1) << AMW) - SW'(1);
    localparam logic [33:0]   SIZE_MAX  = 34'hFFFF_FFFF;

    seq_state_t state_reg, state_next;

    kind_t                kind_reg, kind_next;
    logic [31:0]          addr_reg, addr_next;
    logic [31:0]          req_reg, req_next;
    logic [32:0]          sz_reg, sz_next;
    logic [SW-1:0]        ins_s_reg, ins_s_next;
    logic [31:0]          ins_b_reg, ins_b_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 wv_reg, wv_next;
    logic [IW-1:0]        widx_reg, widx_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 up_reg, up_next;
    logic [FW:0]          pos_reg, pos_next;
    ext_t                 prev_reg, prev_next;
    ext_t                 cur_reg, cur_next;
    logic [UW-1:0]        u_reg, u_next;
    logic [31:0]          have_reg, have_next;
    logic                 wp_reg, wp_next;
    logic [31:0]          merged_reg, merged_next;
    logic [SW-1:0]        end_reg, end_next;
    status_t              status_reg, status_next;
    logic [31:0]          paddr_reg, paddr_next;
    logic [31:0]          granted_reg, granted_next;
    logic [FW:0]          count_reg, count_next;
    logic [MAX_USED_BLOCKS-1:0] valid_reg, valid_next;

    logic        acc_zero;
    logic        scan_end;
    logic        f_hit;
    logic        u_hit;
    logic        v_free;
    logic        v_last;
    logic        a_split;
    logic        s_grow;
    logic        s_split;
    logic        r1_zero;
    logic [32:0] r1_base;
    logic [32:0] r1_diff;
    logic [SW-1:0] r2_lim;
    logic [32:0] r2_len;
    logic        r2_zero;
    logic [32:0] r2_pay;
    logic        m1_wp;
    logic [33:0] m1_t;
    logic [33:0] m2_t;
    logic        m2_wn;
    logic        sh_done;

    // Conditions shared by the next-state and datapath blocks.
    always_comb
    begin
        acc_zero = ((req_in.kind == KIND_ALLOC) && (req_in.request_size == '0))
                || ((req_in.kind == KIND_FREE) && (req_in.address == '0))
                || ((req_in.kind == KIND_SHRINK)
                    && ((req_in.address == '0) || (req_in.request_size == '0)));
        scan_end = !chk_vld_reg && (idx_reg != '0);
        if (kind_reg == KIND_ALLOC)
        begin
            f_hit = chk_vld_reg && ({1'b0, f_rd.bytes} >= sz_reg);
        end
        else
        begin
            f_hit = chk_vld_reg && (f_rd.start >= ins_s_reg);
        end
        u_hit   = chk_vld_reg && valid_reg[chk_idx_reg[UW-1:0]]
                  && (u_rd.start == SW'(addr_reg));
        v_free  = !valid_reg[idx_reg[UW-1:0]];
        v_last  = (idx_reg == IW'(MAX_USED_BLOCKS - 1));
        a_split = {2'b00, cur_reg.bytes}
                  >= ({1'b0, sz_reg} + 34'(HDR_BYTES + MIN_SPLIT));
        s_grow  = sz_reg > {1'b0, have_reg};
        s_split = {2'b00, have_reg}
                  >= ({1'b0, sz_reg} + 34'(HDR_BYTES + MIN_SPLIT));

        // Region placement, first step: align the base.
        r1_base = round_grain(addr_reg);
        r1_diff = r1_base - {1'b0, addr_reg};
        r1_zero = (SW'(r1_base) > ADDR_MASK) || ({1'b0, req_reg} <= r1_diff);

        // Region placement, second step: clip at the end of the space.
        r2_lim = ADDR_MASK - ins_s_reg;
        if (SW'(ins_b_reg - 32'd1) > r2_lim)
        begin
            r2_len = 33'(r2_lim + SW'(1));
        end
        else
        begin
            r2_len = {1'b0, ins_b_reg};
        end
        r2_zero = r2_len < 33'(HDR_BYTES + MIN_SPLIT);
        r2_pay  = (r2_len - 33'(HDR_BYTES)) & ~33'(GRAIN - 1);

        // Merge with the extent below, then with the one above.
        m1_t  = {2'b00, prev_reg.bytes} + 34'(HDR_BYTES) + {2'b00, ins_b_reg};
        m1_wp = (pos_reg != '0)
                && ((prev_reg.start + SW'(HDR_BYTES) + SW'(prev_reg.bytes)) == ins_s_reg)
                && (m1_t <= SIZE_MAX);
        m2_t  = {2'b00, merged_reg} + 34'(HDR_BYTES) + {2'b00, cur_reg.bytes};
        m2_wn = (pos_reg < count_reg) && (end_reg == cur_reg.start) && (m2_t <= SIZE_MAX);

        sh_done = (cnt_reg == '0) && !wv_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (acc_zero)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unique case (req_in.kind)
                            KIND_ALLOC:              state_next = S_FSCAN;
                            KIND_FREE, KIND_SHRINK:  state_next = S_USCAN;
                            KIND_REGION:             state_next = S_REG1;
                            default:                 state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_REG1:
            begin
                state_next = r1_zero ? S_DONE : S_REG2;
            end
            S_REG2:
            begin
                state_next = r2_zero ? S_DONE : S_FSCAN;
            end
            S_FSCAN:
            begin
                if (f_hit)
                begin
                    state_next = (kind_reg == KIND_ALLOC) ? S_VSCAN : S_MRG1;
                end
                else if (scan_end)
                begin
                    state_next = (kind_reg == KIND_ALLOC) ? S_DONE : S_MRG1;
                end
            end
            S_VSCAN:
            begin
                if (v_free)
                begin
                    state_next = S_ACOM;
                end
                else if (v_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ACOM:
            begin
                state_next = a_split ? S_DONE : S_SHIFT;
            end
            S_USCAN:
            begin
                if (u_hit)
                begin
                    state_next = (kind_reg == KIND_FREE) ? S_FSCAN : S_SHRK;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHRK:
            begin
                state_next = (!s_grow && s_split) ? S_FSCAN : S_DONE;
            end
            S_MRG1:
            begin
                state_next = S_MRG2;
            end
            S_MRG2:
            begin
                if (wp_reg)
                begin
                    state_next = m2_wn ? S_SHIFT : S_INSFIN;
                end
                else if (m2_wn)
                begin
                    state_next = S_INSFIN;
                end
                else if (count_reg >= (FW + 1)'(MAX_FREE_EXTENTS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sh_done)
                begin
                    if (!up_reg && (kind_reg == KIND_ALLOC))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INSFIN;
                    end
                end
            end
            S_INSFIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, table writes and outputs.
    always_comb
    begin
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        req_next     = req_reg;
        sz_next      = sz_reg;
        ins_s_next   = ins_s_reg;
        ins_b_next   = ins_b_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = idx_reg;
        wv_next      = 1'b0;
        widx_next    = widx_reg;
        cnt_next     = cnt_reg;
        up_next      = up_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        u_next       = u_reg;
        have_next    = have_reg;
        wp_next      = wp_reg;
        merged_next  = merged_reg;
        end_next     = end_reg;
        status_next  = status_reg;
        paddr_next   = paddr_reg;
        granted_next = granted_reg;
        count_next   = count_reg;
        valid_next   = valid_reg;

        f_we = 1'b0;
        f_wa = pos_reg[FW-1:0];
        f_wd = '{start: ins_s_reg, bytes: ins_b_reg};
        u_we = 1'b0;
        u_wa = u_reg;
        u_wd = '{start: SW'(addr_reg), bytes: sz_reg[31:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = req_in.kind;
                    addr_next    = req_in.address;
                    req_next     = req_in.request_size;
                    sz_next      = round_grain(req_in.request_size);
                    status_next  = acc_zero ? ST_ZERO : ST_OK;
                    paddr_next   = req_in.address;
                    granted_next = '0;
                    idx_next     = '0;
                end
            end
            S_REG1:
            begin
                ins_s_next = SW'(r1_base);
                ins_b_next = req_reg - r1_diff[31:0];
                if (r1_zero)
                begin
                    status_next = ST_ZERO;
                end
            end
            S_REG2:
            begin
                ins_b_next = r2_pay[31:0];
                idx_next   = '0;
                if (r2_zero)
                begin
                    status_next = ST_ZERO;
                end
            end
            S_FSCAN:
            begin
                idx_next     = idx_reg + 1'b1;
                chk_vld_next = idx_reg < IW'(count_reg);
                if (f_hit)
                begin
                    pos_next     = chk_idx_reg[FW:0];
                    cur_next     = f_rd;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                end
                else if (chk_vld_reg)
                begin
                    prev_next = f_rd;
                end
                else if (scan_end)
                begin
                    pos_next     = count_reg;
                    chk_vld_next = 1'b0;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        status_next = ST_NOFIT;
                    end
                end
            end
            S_VSCAN:
            begin
                if (v_free)
                begin
                    u_next = idx_reg[UW-1:0];
                end
                else if (v_last)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ACOM:
            begin
                // Claim the used slot and cut the extent or drop it whole.
                u_we              = 1'b1;
                u_wd.start        = cur_reg.start + SW'(HDR_BYTES);
                u_wd.bytes        = a_split ? sz_reg[31:0] : cur_reg.bytes;
                valid_next[u_reg] = 1'b1;
                paddr_next        = 32'(cur_reg.start + SW'(HDR_BYTES));
                granted_next      = a_split ? sz_reg[31:0] : cur_reg.bytes;
                if (a_split)
                begin
                    f_we       = 1'b1;
                    f_wd.start = cur_reg.start + SW'(HDR_BYTES) + SW'(sz_reg);
                    f_wd.bytes = cur_reg.bytes - sz_reg[31:0] - 32'(HDR_BYTES);
                end
                else
                begin
                    cnt_next = IW'(count_reg - pos_reg - 1'b1);
                    idx_next = IW'(pos_reg) + 1'b1;
                    up_next  = 1'b0;
                end
            end
            S_USCAN:
            begin
                idx_next     = idx_reg + 1'b1;
                chk_vld_next = idx_reg < IW'(MAX_USED_BLOCKS);
                if (u_hit)
                begin
                    u_next       = chk_idx_reg[UW-1:0];
                    have_next    = u_rd.bytes;
                    ins_s_next   = SW'(addr_reg) - SW'(HDR_BYTES);
                    ins_b_next   = u_rd.bytes;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                end
                else if (scan_end)
                begin
                    status_next  = ST_NOTALLOC;
                    chk_vld_next = 1'b0;
                end
            end
            S_SHRK:
            begin
                idx_next = '0;
                if (s_grow)
                begin
                    status_next  = ST_GROW;
                    granted_next = have_reg;
                end
                else if (s_split)
                begin
                    ins_s_next = SW'(addr_reg) + SW'(sz_reg);
                    ins_b_next = have_reg - sz_reg[31:0] - 32'(HDR_BYTES);
                end
                else
                begin
                    granted_next = have_reg;
                end
            end
            S_MRG1:
            begin
                wp_next     = m1_wp;
                merged_next = m1_wp ? m1_t[31:0] : ins_b_reg;
                end_next    = ins_s_reg + SW'(HDR_BYTES) + SW'(ins_b_reg);
            end
            S_MRG2:
            begin
                if (wp_reg)
                begin
                    // Grow the extent below; an absorbed upper one is removed.
                    f_we       = 1'b1;
                    f_wa       = FW'(pos_reg - 1'b1);
                    f_wd.start = prev_reg.start;
                    f_wd.bytes = m2_wn ? m2_t[31:0] : merged_reg;
                    if (m2_wn)
                    begin
                        cnt_next = IW'(count_reg - pos_reg - 1'b1);
                        idx_next = IW'(pos_reg) + 1'b1;
                        up_next  = 1'b0;
                    end
                end
                else if (m2_wn)
                begin
                    f_we       = 1'b1;
                    f_wd.bytes = m2_t[31:0];
                end
                else if (count_reg >= (FW + 1)'(MAX_FREE_EXTENTS))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = IW'(count_reg - pos_reg);
                    idx_next = IW'(count_reg) - 1'b1;
                    up_next  = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // One entry moves per cycle: read now, write next cycle.
                if (cnt_reg != '0)
                begin
                    wv_next   = 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    widx_next = up_reg ? (idx_reg + 1'b1) : (idx_reg - 1'b1);
                    idx_next  = up_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                end
                if (wv_reg)
                begin
                    f_we = 1'b1;
                    f_wa = widx_reg[FW-1:0];
                    f_wd = f_rd;
                end
                if (sh_done)
                begin
                    if (up_reg)
                    begin
                        f_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_INSFIN:
            begin
                unique case (kind_reg)
                    KIND_FREE:
                    begin
                        valid_next[u_reg] = 1'b0;
                        granted_next      = have_reg;
                    end
                    KIND_SHRINK:
                    begin
                        u_we         = 1'b1;
                        granted_next = sz_reg[31:0];
                    end
                    KIND_REGION:
                    begin
                        granted_next = ins_b_reg;
                    end
                    default:
                    begin
                        granted_next = granted_reg;
                    end
                endcase
            end
            S_DONE:
            begin
                idx_next = '0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Read addresses follow the scan index in every state.
    assign f_ra = idx_reg[FW-1:0];
    assign u_ra = idx_reg[UW-1:0];

    assign idle                = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res.status          = status_reg;
    assign res.payload_address = paddr_reg;
    assign res.granted_size    = granted_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            wv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
            wv_reg      <= wv_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        req_reg     <= req_next;
        sz_reg      <= sz_next;
        ins_s_reg   <= ins_s_next;
        ins_b_reg   <= ins_b_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        widx_reg    <= widx_next;
        cnt_reg     <= cnt_next;
        up_reg      <= up_next;
        pos_reg     <= pos_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        u_reg       <= u_next;
        have_reg    <= have_next;
        wp_reg      <= wp_next;
        merged_reg  <= merged_next;
        end_reg     <= end_next;
        status_reg  <= status_next;
        paddr_reg   <= paddr_next;
        granted_reg <= granted_next;
    end

endmodule

`default_nettype wire

// ===== rtl/first_fit_coalescing_allocator.sv =====
// Usage: requests arrive on req (kind, address, request_size) and each one
// returns exactly one word on rsp (status, payload_address, granted_size).
// Both channels move a word when valid and ready are high at a clock edge.
// One request is worked on at a time; req.ready is high while the sequencer
// is idle, also when an earlier response still waits in the output register.
// Each request walks the tables one entry per cycle:
//   alloc: a free-table scan, a used-slot scan, a commit, and a shift to
//          close the gap when an extent is used whole.
//   free/shrink: a used-table lookup (shrink adds a size check), then
//          the insert: a scan, a merge with the extents below and above,
//          a shift where one is needed, and a finish step.
//   add region: base alignment and end clipping, then the insert.
// Reset empties both tables at once (free count and used valid bits clear);
// no clearing pass is needed. A stalled rsp holds its word; the block then
// finishes the next request and waits until the output register frees up.
`default_nettype none

// ---------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit heap allocator with address-ordered, coalescing free extents.
// ---------------------------------------------------------------------------
module first_fit_coalescing_allocator import ffca_pkg::*; #(
    parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
    parameter int MAX_USED_BLOCKS  = DEF_MAX_USED_BLOCKS,
    parameter int ADDR_BITS        = DEF_ADDR_BITS
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ffca_req_if.sink   req,
    ffca_rsp_if.source rsp
);

    localparam int FW = $clog2(MAX_FREE_EXTENTS);
    localparam int UW = $clog2(MAX_USED_BLOCKS);

    logic          idle;
    logic          start;
    req_t          req_in;
    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic [FW-1:0] f_ra;
    logic [FW-1:0] f_wa;
    logic          f_we;
    ext_t          f_rd;
    ext_t          f_wd;
    logic [UW-1:0] u_ra;
    logic [UW-1:0] u_wa;
    logic          u_we;
    ext_t          u_rd;
    ext_t          u_wd;

    logic out_valid_reg, out_valid_next;
    res_t out_word_reg;

    // Request intake.
    assign req.ready           = idle;
    assign start               = req.valid && idle;
    assign req_in.kind         = kind_t'(req.kind);
    assign req_in.address      = req.address;
    assign req_in.request_size = req.request_size;

    // Free extent table, kept sorted by header address.
    ffca_ram #(
        .DEPTH (MAX_FREE_EXTENTS),
        .WIDTH ($bits(ext_t))
    ) u_free_ram (
        .clk (clk),
        .we  (f_we),
        .wa  (f_wa),
        .wd  (f_wd),
        .ra  (f_ra),
        .rd  (f_rd)
    );

    // Allocated block table.
    ffca_ram #(
        .DEPTH (MAX_USED_BLOCKS),
        .WIDTH ($bits(ext_t))
    ) u_used_ram (
        .clk (clk),
        .we  (u_we),
        .wa  (u_wa),
        .wd  (u_wd),
        .ra  (u_ra),
        .rd  (u_rd)
    );

    ffca_seq #(
        .MAX_FREE_EXTENTS (MAX_FREE_EXTENTS),
        .MAX_USED_BLOCKS  (MAX_USED_BLOCKS),
        .ADDR_BITS        (ADDR_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_in    (req_in),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .f_ra      (f_ra),
        .f_rd      (f_rd),
        .f_we      (f_we),
        .f_wa      (f_wa),
        .f_wd      (f_wd),
        .u_ra      (u_ra),
        .u_rd      (u_rd),
        .u_we      (u_we),
        .u_wa      (u_wa),
        .u_wd      (u_wd)
    );

    // Output register: loads when empty or when its word is taken.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_word_reg.status;
    assign rsp.payload_address = out_word_reg.payload_address;
    assign rsp.granted_size    = out_word_reg.granted_size;

endmodule

`default_nettype wire

// ===== rtl/ffca_checker.sv =====
// ---------------------------------------------------------------------------
// ffca_checker
// Port-level checks on the allocator response channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "first_fit_coalescing_allocator_assert.svh"

module ffca_checker import ffca_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [31:0] rsp_payload_address,
    input wire logic [31:0] rsp_granted_size
);

    // Only defined status codes leave the block.
    `FFCA_ASSERT_IMPL(a_status_code, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_ZERO) || (rsp_status == ST_NOFIT) || (rsp_status == ST_NOTALLOC) || (rsp_status == ST_FULL) || (rsp_status == ST_GROW))

    // A failing request grants nothing, except the grow report.
    `FFCA_ASSERT_IMPL(a_fail_no_grant, rsp_valid && ((rsp_status == ST_ZERO) || (rsp_status == ST_NOFIT) || (rsp_status == ST_NOTALLOC) || (rsp_status == ST_FULL)), rsp_granted_size == '0)

    // Every reported size is a whole number of grains.
    `FFCA_ASSERT_IMPL(a_grant_grain, rsp_valid, rsp_granted_size[3:0] == 4'd0)

    // A stalled response word holds.
    `FFCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_payload_address) && $stable(rsp_granted_size))

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_payload_address (rsp.payload_address),
    .rsp_granted_size    (rsp.granted_size)
);

`default_nettype wire
